[rtl/audio_sample_format_converter_unit_macros.svh]
// Assertion helpers for the converter RTL.
`ifndef AUDIO_SAMPLE_FORMAT_CONVERTER_UNIT_MACROS_SVH
`define AUDIO_SAMPLE_FORMAT_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASFC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/asfc_pkg.sv]
package asfc_pkg;

    localparam int SAMPLE_W    = 64;
    localparam int RESULT_W    = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 3;

    localparam logic [2:0] SRC_UINT8   = 3'd0;
    localparam logic [2:0] SRC_INT8    = 3'd1;
    localparam logic [2:0] SRC_INT16   = 3'd2;
    localparam logic [2:0] SRC_INT24   = 3'd3;
    localparam logic [2:0] SRC_INT32   = 3'd4;
    localparam logic [2:0] SRC_FLOAT32 = 3'd5;
    localparam logic [2:0] SRC_FLOAT64 = 3'd6;

    localparam logic [2:0] TGT_UINT8   = 3'd0;
    localparam logic [2:0] TGT_INT8    = 3'd1;
    localparam logic [2:0] TGT_INT16   = 3'd2;
    localparam logic [2:0] TGT_INT32   = 3'd3;
    localparam logic [2:0] TGT_FLOAT32 = 3'd4;

    localparam logic [1:0] CFG_SOURCE_FORMAT    = 2'd0;
    localparam logic [1:0] CFG_TARGET_FORMAT    = 2'd1;
    localparam logic [1:0] CFG_INT24_BIG_ENDIAN = 2'd2;

    // single-precision mantissas (hidden bit included) of 1/127 and 1/32767
    localparam logic [23:0] MANT_INV127   = 24'h810204;
    localparam logic [23:0] MANT_INV32767 = 24'h800100;

    localparam logic [31:0] FLOAT_QNAN = 32'h7FC00000;
    localparam logic [30:0] FLOAT_INF  = 31'h7F800000;

    typedef struct packed {
        logic [2:0] source_format;
        logic [2:0] target_format;
        logic       int24_big_endian;
    } cfg_t;

endpackage

[rtl/audio_sample_format_converter_unit.sv]
// PCM sample format converter.
// Input stream s_axis_*: one source sample per beat in tdata, buffer end in tlast.
// Output stream m_axis_*: one converted sample per beat, tlast copied through.
// Configuration: cfg_we with cfg_index/cfg_wdata writes source_format (0),
// target_format (1) or int24_big_endian (2); write only while the stream is idle.
// Path: a beat accepted into the input register passes through one combinational
// conversion stage (24x24 multiply or shift-subtract scaling plus rounding) into
// the result register, from which m_axis offers it. Throughput: one sample per
// cycle while the result register is not held by a low m_axis_tready.
// Reset clears both pipeline valids and sets the configuration to uint8 -> uint8.
// When m_axis_tready is low the result register holds, the input register
// fills once more, and s_axis_tready then drops until the result is taken.
module audio_sample_format_converter_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [asfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [asfc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [asfc_pkg::SAMPLE_W-1:0]    s_axis_tdata,  // [63:0] sample_bits
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [asfc_pkg::RESULT_W-1:0]    m_axis_tdata,  // [31:0] result_bits
    output logic                             m_axis_tlast
);
    import asfc_pkg::*;

    cfg_t                cfg_reg;
    logic                s1_vld_reg;
    logic [SAMPLE_W-1:0] s1_data_reg;
    logic                s1_last_reg;
    logic                out_vld_reg;
    logic [RESULT_W-1:0] out_data_reg;
    logic                out_last_reg;
    logic [RESULT_W-1:0] res_next;
    logic                advance;

    logic [2:0]  src;
    logic [2:0]  tgt;
    logic [63:0] d;
    logic [31:0] al;

    logic [31:0] ix;
    logic [31:0] imag;
    logic [31:0] inorm;
    logic [4:0]  ilz;
    logic [31:0] iwide;
    logic [7:0]  ieb_w;
    logic        iinc_w;
    logic [23:0] imk;
    logic [47:0] ip48;
    logic        ihi;
    logic [22:0] ikeep;
    logic        ig;
    logic        ist;
    logic        ilsb;
    logic [7:0]  ieb_n;
    logic [31:0] inarrow;
    logic [31:0] ifloat;

    logic               fsgl;
    logic               fsign;
    logic signed [11:0] fexp;
    logic [52:0]        fm;
    logic               fnan;
    logic               finf;
    logic               fzero;

    logic [67:0] fp;
    logic        ftop;
    logic [6:0]  fl;
    logic [67:0] fmask;
    logic        finc;
    logic [68:0] fq;
    logic [6:0]  fsh;
    logic [68:0] fip;
    logic        fbig;
    logic        fsmall;
    logic [15:0] fmag;
    logic [7:0]  cm7;
    logic [7:0]  cm8;
    logic [14:0] cm15;
    logic [7:0]  u8;
    logic [7:0]  i8;
    logic [15:0] i16;

    logic [5:0]  sh32;
    logic [52:0] mag32;
    logic [31:0] r32;

    logic signed [11:0] deb;
    logic [30:0]        dbase;
    logic               dinc;
    logic [5:0]         shd;
    logic [116:0]       dfull;
    logic [31:0]        r64;

    assign advance       = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = !s1_vld_reg || advance;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SOURCE_FORMAT:    cfg_reg.source_format    <= cfg_wdata;
                CFG_TARGET_FORMAT:    cfg_reg.target_format    <= cfg_wdata;
                CFG_INT24_BIG_ENDIAN: cfg_reg.int24_big_endian <= cfg_wdata[0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_vld_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_vld_reg <= s1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            s1_data_reg <= s_axis_tdata;
            s1_last_reg <= s_axis_tlast;
        end
        if (advance && s1_vld_reg)
        begin
            out_data_reg <= res_next;
            out_last_reg <= s1_last_reg;
        end
    end

    assign src = cfg_reg.source_format;
    assign tgt = cfg_reg.target_format;
    assign d   = s1_data_reg;

    always_comb
    begin
        case (src)
            SRC_UINT8: al = {d[7:0] ^ 8'h80, 24'h0};
            SRC_INT8:  al = {d[7:0], 24'h0};
            SRC_INT16: al = {d[15:0], 16'h0};
            SRC_INT24: al = cfg_reg.int24_big_endian ? {d[7:0], d[15:8], d[23:16], 8'h0}
                                                     : {d[23:16], d[15:8], d[7:0], 8'h0};
            default:   al = d[31:0];
        endcase
    end

    // integer to float32
    always_comb
    begin
        if (src <= SRC_INT8)
            ix = {{24{al[31]}}, al[31:24]};
        else if (src == SRC_INT16)
            ix = {{16{al[31]}}, al[31:16]};
        else
            ix = al;
        imag = ix[31] ? (~ix + 32'd1) : ix;

        inorm = imag;
        ilz   = 5'd0;
        if (inorm[31:16] == 16'h0)
        begin
            inorm  = inorm << 16;
            ilz[4] = 1'b1;
        end
        if (inorm[31:24] == 8'h0)
        begin
            inorm  = inorm << 8;
            ilz[3] = 1'b1;
        end
        if (inorm[31:28] == 4'h0)
        begin
            inorm  = inorm << 4;
            ilz[2] = 1'b1;
        end
        if (inorm[31:30] == 2'h0)
        begin
            inorm  = inorm << 2;
            ilz[1] = 1'b1;
        end
        if (!inorm[31])
        begin
            inorm  = inorm << 1;
            ilz[0] = 1'b1;
        end

        ieb_w  = 8'd127 - {3'b0, ilz};
        iinc_w = inorm[7] & ((|inorm[6:0]) | inorm[8]);
        iwide  = {ix[31], {ieb_w, inorm[30:8]} + {30'b0, iinc_w}};

        imk   = (src <= SRC_INT8) ? MANT_INV127 : MANT_INV32767;
        ip48  = inorm[31:8] * imk;
        ihi   = ip48[47];
        ikeep = ihi ? ip48[46:24] : ip48[45:23];
        ig    = ihi ? ip48[23] : ip48[22];
        ist   = ihi ? (|ip48[22:0]) : (|ip48[21:0]);
        ilsb  = ihi ? ip48[24] : ip48[23];
        ieb_n = ((src <= SRC_INT8) ? 8'd120 : 8'd112) + {3'b0, 5'd31 - ilz} + {7'b0, ihi};
        inarrow = {ix[31], {ieb_n, ikeep} + {30'b0, ig & (ist | ilsb)}};

        if (imag == 32'h0)
            ifloat = 32'h0;
        else if (src >= SRC_INT24)
            ifloat = iwide;
        else
            ifloat = inarrow;
    end

    // float unpack
    always_comb
    begin
        fsgl = (src == SRC_FLOAT32);
        if (fsgl)
        begin
            fsign = d[31];
            fexp  = {4'b0, d[30:23]} - 12'sd127;
            fm    = {1'b1, d[22:0], 29'b0};
            fnan  = (&d[30:23]) && (|d[22:0]);
            finf  = (&d[30:23]) && !(|d[22:0]);
            fzero = (d[30:23] == 8'h0);
        end
        else
        begin
            fsign = d[63];
            fexp  = {1'b0, d[62:52]} - 12'sd1023;
            fm    = {1'b1, d[51:0]};
            fnan  = (&d[62:52]) && (|d[51:0]);
            finf  = (&d[62:52]) && !(|d[51:0]);
            fzero = (d[62:52] == 11'h0);
        end
    end

    // float to 8/16-bit integer: scale, round in source precision, truncate, clamp
    always_comb
    begin
        if (tgt == TGT_INT16)
        begin
            fp   = ({15'b0, fm} << 15) - {15'b0, fm};
            ftop = fp[67];
            fl   = 7'd66 + {6'b0, ftop} - (fsgl ? 7'd23 : 7'd52);
        end
        else
        begin
            fp   = ({15'b0, fm} << 7) - {15'b0, fm};
            ftop = fp[59];
            fl   = 7'd58 + {6'b0, ftop} - (fsgl ? 7'd23 : 7'd52);
        end
        fmask = (68'd1 << fl) - 68'd1;
        finc  = fp[fl - 7'd1] & ((|(fp & (fmask >> 1))) | fp[fl]);
        fq    = {1'b0, fp & ~fmask} + (finc ? (69'd1 << fl) : 69'd0);
        fsh   = 7'(12'sd52 - fexp);
        fip   = fq >> fsh;

        fsmall = fzero || (fexp < -12'sd16);
        fbig   = finf || (fexp >= 12'sd16) || (|fip[68:15]);
        if (fnan || fsmall)
            fmag = 16'h0;
        else if (fbig)
            fmag = 16'hFFFF;
        else
            fmag = {1'b0, fip[14:0]};

        cm7  = (fmag > 16'd127) ? 8'd127 : fmag[7:0];
        cm8  = (fmag > 16'd128) ? 8'd128 : fmag[7:0];
        cm15 = (fmag > 16'd32767) ? 15'h7FFF : fmag[14:0];
        u8   = fsign ? (8'd128 - cm8) : (8'd128 + cm7);
        i8   = fsign ? (~cm7 + 8'd1) : cm7;
        i16  = fsign ? (~{1'b0, cm15} + 16'd1) : {1'b0, cm15};
    end

    // float to int32: clamp to [-1,1], scale by 2^31
    always_comb
    begin
        sh32  = 6'(12'sd21 - fexp);
        mag32 = fm >> sh32;
        if (fnan || fzero || (fexp < -12'sd31))
            r32 = 32'h0;
        else if (finf || (fexp >= 12'sd0))
            r32 = fsign ? 32'h80000000 : 32'h7FFFFFFF;
        else
            r32 = fsign ? (~{1'b0, mag32[30:0]} + 32'd1) : {1'b0, mag32[30:0]};
    end

    // float64 to float32 with round to nearest even
    always_comb
    begin
        deb   = fexp + 12'sd127;
        dbase = {deb[7:0], fm[51:29]};
        dinc  = fm[28] & ((|fm[27:0]) | fm[29]);
        shd   = 6'(12'sd30 - deb);
        dfull = {fm, 64'b0} >> shd;
        if (fnan)
            r64 = FLOAT_QNAN;
        else if (fzero)
            r64 = {fsign, 31'h0};
        else if (finf || (deb >= 12'sd255))
            r64 = {fsign, FLOAT_INF};
        else if (deb >= 12'sd1)
            r64 = {fsign, dbase + {30'b0, dinc}};
        else if (deb < -12'sd30)
            r64 = {fsign, 31'h0};
        else
            r64 = {fsign, dfull[94:64]
                   + {30'b0, dfull[63] & ((|dfull[62:0]) | dfull[64])}};
    end

    always_comb
    begin
        res_next = '0;
        if (src <= SRC_INT32)
        begin
            case (tgt)
                TGT_UINT8:   res_next = {24'h0, al[31:24] ^ 8'h80};
                TGT_INT8:    res_next = {24'h0, al[31:24]};
                TGT_INT16:   res_next = {16'h0, al[31:16]};
                TGT_INT32:   res_next = al;
                TGT_FLOAT32: res_next = ifloat;
                default:     res_next = '0;
            endcase
        end
        else if (src == SRC_FLOAT32 || src == SRC_FLOAT64)
        begin
            case (tgt)
                TGT_UINT8:   res_next = {24'h0, u8};
                TGT_INT8:    res_next = {24'h0, i8};
                TGT_INT16:   res_next = {16'h0, i16};
                TGT_INT32:   res_next = r32;
                TGT_FLOAT32: res_next = fsgl ? d[31:0] : r64;
                default:     res_next = '0;
            endcase
        end
    end

`include "audio_sample_format_converter_unit_macros.svh"

    `ASFC_ASSERT_NOW(a_full_stall, s1_vld_reg && out_vld_reg && !m_axis_tready, !s_axis_tready)
    `ASFC_ASSERT_NOW(a_empty_ready, !out_vld_reg, s_axis_tready)
    `ASFC_ASSERT_NEXT(a_in_load, s_axis_tvalid && s_axis_tready, s1_vld_reg)
    `ASFC_ASSERT_NEXT(a_out_load, advance && s1_vld_reg, out_vld_reg)

endmodule
